/* src/lses_pkg.sv */
`default_nettype none

package lses_pkg;

  // Action codes
  localparam logic [2:0] ACT_PUSH       = 3'd0;
  localparam logic [2:0] ACT_POP        = 3'd1;
  localparam logic [2:0] ACT_TOP        = 3'd2;
  localparam logic [2:0] ACT_BREAK      = 3'd3;
  localparam logic [2:0] ACT_BREAK_USED = 3'd4;
  localparam logic [2:0] ACT_CONT       = 3'd5;
  localparam logic [2:0] ACT_CONT_USED  = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  // Entry kinds
  localparam logic KIND_LOOP   = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  localparam int unsigned EXIT_W  = 16;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned ENTRY_W = EXIT_W + 2;

  typedef struct packed {
    logic [2:0]        action;
    logic              kind;
    logic [EXIT_W-1:0] exit_number;
  } in_item_t;

  typedef struct packed {
    logic [EXIT_W-1:0]  exit_result;
    logic               not_empty;
    logic [1:0]         status;
    logic [LEVEL_W-1:0] level;
  } out_item_t;

  typedef struct packed {
    logic              kind;
    logic              used;
    logic [EXIT_W-1:0] exit_num;
  } entry_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic eval;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;
    logic eval_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* src/lses_ram.sv */
`default_nettype none

module lses_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/lses_ctrl.sv */
`default_nettype none

module lses_ctrl
  import lses_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_EVAL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = sts_i.need_read ? S_EVAL : S_FINISH;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.eval_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/lses_dp.sv */
`default_nettype none

module lses_dp
  import lses_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_item_i,
  input  wire ctrl_cmd_t cmd_i,
  output ctrl_sts_t      sts_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o,
  // entry memory
  output logic               ram_we_o,
  output logic [IDX_W-1:0]   ram_waddr_o,
  output logic [ENTRY_W-1:0] ram_wdata_o,
  output logic [IDX_W-1:0]   ram_raddr_o,
  input  wire logic [ENTRY_W-1:0] ram_rdata_i
);

  in_item_t          item_q;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [EXIT_W-1:0] result_q, result_d;
  logic [1:0]        status_q, status_d;
  out_item_t         out_q;
  logic              out_valid_q;

  logic             empty;
  logic             full;
  logic [IDX_W-1:0] top_idx;
  entry_t           rd_entry;
  entry_t           wr_entry;

  assign empty    = (level_q == '0);
  assign full     = (level_q == LVL_W'(STACK_DEPTH));
  assign top_idx  = IDX_W'(level_q - LVL_W'(1));
  assign rd_entry = entry_t'(ram_rdata_i);

  assign ram_raddr_o = idx_d;
  assign ram_wdata_o = wr_entry;

  always_comb begin
    level_d         = level_q;
    idx_d           = idx_q;
    result_d        = result_q;
    status_d        = status_q;
    ram_we_o        = 1'b0;
    ram_waddr_o     = idx_q;
    wr_entry        = rd_entry;
    sts_o.need_read = 1'b0;
    sts_o.eval_done = 1'b0;
    sts_o.out_free  = !out_valid_q || !out_stall_i;

    if (cmd_i.decode) begin
      result_d = '0;
      status_d = ST_OK;
      idx_d    = top_idx;
      case (item_q.action)
        ACT_PUSH: begin
          if (item_q.exit_number == '0) begin
            status_d = ST_ZERO;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ram_we_o          = 1'b1;
            ram_waddr_o       = IDX_W'(level_q);
            wr_entry.kind     = item_q.kind;
            wr_entry.used     = 1'b0;
            wr_entry.exit_num = item_q.exit_number;
            level_d           = level_q + LVL_W'(1);
          end
        end
        ACT_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            level_d = level_q - LVL_W'(1);
          end
        end
        ACT_BREAK, ACT_BREAK_USED: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            sts_o.need_read = 1'b1;
          end
        end
        ACT_TOP, ACT_CONT, ACT_CONT_USED: begin
          sts_o.need_read = !empty;
        end
        default: ;
      endcase
    end

    if (cmd_i.eval) begin
      case (item_q.action)
        ACT_TOP: begin
          result_d        = rd_entry.exit_num;
          sts_o.eval_done = 1'b1;
        end
        ACT_BREAK: begin
          if (rd_entry.kind == KIND_SWITCH) begin
            result_d      = rd_entry.exit_num;
            ram_we_o      = 1'b1;
            wr_entry.used = 1'b1;
          end
          sts_o.eval_done = 1'b1;
        end
        ACT_BREAK_USED: begin
          if (rd_entry.kind == KIND_SWITCH && rd_entry.used) begin
            result_d = rd_entry.exit_num;
          end
          sts_o.eval_done = 1'b1;
        end
        ACT_CONT, ACT_CONT_USED: begin
          // walk down from the top, skipping switches
          if (rd_entry.kind == KIND_LOOP) begin
            if (item_q.action == ACT_CONT) begin
              result_d      = rd_entry.exit_num;
              ram_we_o      = 1'b1;
              wr_entry.used = 1'b1;
            end else if (rd_entry.used) begin
              result_d = rd_entry.exit_num;
            end
            sts_o.eval_done = 1'b1;
          end else if (idx_q == '0) begin
            sts_o.eval_done = 1'b1;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
        default: sts_o.eval_done = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    idx_q    <= idx_d;
    result_q <= result_d;
    status_q <= status_d;
    if (cmd_i.finish) begin
      out_q.exit_result <= result_q;
      out_q.not_empty   <= !empty;
      out_q.status      <= status_q;
      out_q.level       <= LEVEL_W'(level_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      level_q <= level_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // drop valid once the result transfer completes
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* src/loop_switch_exit_stack_core.sv */
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_i  (in_item_t)
// out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//
// One item at a time: accept, decode, evaluate (reading the entry RAM),
// then load the output register. Push, pop and empty cases skip evaluation;
// top and break read the top entry; continue walks down to the nearest loop
// (up to STACK_DEPTH entries) through the single RAM read port. Reset clears
// the level and output valid; entries need no clear. A stalled result holds
// in the output register while the next item is taken.
`default_nettype none

module loop_switch_exit_stack_core
  import lses_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  lses_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lses_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lses_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

/* bench/loop_switch_exit_stack_core_tb.sv */
`timescale 1ns / 1ps

module loop_switch_exit_stack_core_tb;
  import lses_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned N_RANDOM       = 500;
  localparam int unsigned HOLD_AT        = 200;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Action 7 has no meaning: the block answers it without touching the stack.
  localparam logic [2:0] ACT_NONE = 3'd7;

  typedef struct packed {
    in_item_t   op;
    logic [4:0] reps;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_stall_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Stack as the block should hold it.
  logic              stk_kind [DEPTH];
  logic              stk_used [DEPTH];
  logic [EXIT_W-1:0] stk_exit [DEPTH];
  int unsigned       stk_level = 0;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  int unsigned n_mismatch   = 0;
  int unsigned n_checked    = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_directed   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned burst_left   = 0;
  int unsigned deepest      = 0;
  int unsigned n_full       = 0;
  int unsigned n_zero       = 0;
  int unsigned n_empty      = 0;
  int unsigned longest_walk = 0;

  loop_switch_exit_stack_core #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Apply one action to the stack and return the result the block should give.
  function automatic out_item_t step_stack(input in_item_t it);
    out_item_t r;
    int        loop_idx;
    int        top;
    r        = '0;
    r.status = ST_OK;
    loop_idx = -1;
    top      = int'(stk_level) - 1;
    case (it.action)
      ACT_PUSH: begin
        // zero exit number wins over a full stack
        if (it.exit_number == '0) begin
          r.status = ST_ZERO;
          n_zero++;
        end else if (stk_level >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          stk_kind[stk_level] = it.kind;
          stk_exit[stk_level] = it.exit_number;
          stk_used[stk_level] = 1'b0;
          stk_level++;
        end
      end
      ACT_POP: begin
        if (stk_level == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          stk_level--;
        end
      end
      ACT_TOP: begin
        if (stk_level != 0) r.exit_result = stk_exit[top];
      end
      ACT_BREAK, ACT_BREAK_USED: begin
        if (stk_level == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else if (stk_kind[top] == KIND_SWITCH) begin
          if (it.action == ACT_BREAK) begin
            r.exit_result = stk_exit[top];
            stk_used[top] = 1'b1;
          end else if (stk_used[top]) begin
            r.exit_result = stk_exit[top];
          end
        end
      end
      ACT_CONT, ACT_CONT_USED: begin
        // search down from the top, skipping switches
        for (int i = top; i >= 0; i--) begin
          if (loop_idx < 0 && stk_kind[i] == KIND_LOOP) loop_idx = i;
        end
        if (loop_idx >= 0) begin
          if (int'(stk_level) - loop_idx > int'(longest_walk)) begin
            longest_walk = stk_level - loop_idx;
          end
          if (it.action == ACT_CONT) begin
            r.exit_result      = stk_exit[loop_idx];
            stk_used[loop_idx] = 1'b1;
          end else if (stk_used[loop_idx]) begin
            r.exit_result = stk_exit[loop_idx];
          end
        end
      end
      default: ;
    endcase
    if (stk_level > deepest) deepest = stk_level;
    r.not_empty = (stk_level != 0);
    r.level     = stk_level[LEVEL_W-1:0];
    return r;
  endfunction

  // Phase 0 fills the stack, phase 1 mixes, phase 2 drains it.
  function automatic in_item_t draw_op(input int unsigned phase);
    in_item_t    it;
    int unsigned pick;
    int unsigned push_pct;
    int unsigned pop_pct;
    push_pct = (phase == 0) ? 55 : (phase == 1) ? 30 : 10;
    pop_pct  = (phase == 0) ? 10 : (phase == 1) ? 25 : 50;
    it.kind  = ($urandom_range(0, 9) < 6) ? KIND_SWITCH : KIND_LOOP;
    case ($urandom_range(0, 19))
      0:       it.exit_number = '0;
      1:       it.exit_number = '1;
      default: it.exit_number = EXIT_W'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < push_pct) begin
      it.action = ACT_PUSH;
    end else if (pick < push_pct + pop_pct) begin
      it.action = ACT_POP;
    end else if (pick >= 98) begin
      it.action = ACT_NONE;
    end else begin
      case ($urandom_range(0, 4))
        0:       it.action = ACT_TOP;
        1:       it.action = ACT_BREAK;
        2:       it.action = ACT_BREAK_USED;
        3:       it.action = ACT_CONT;
        default: it.action = ACT_CONT_USED;
      endcase
    end
    return it;
  endfunction

  task automatic add_row(input logic [2:0] act, input logic kind, input logic [15:0] exitnum,
                         input int unsigned reps, input logic typed,
                         input logic [15:0] w_exit, input logic w_ne,
                         input logic [1:0] w_st, input logic [4:0] w_lvl);
    dir_row_t row;
    row.op.action        = act;
    row.op.kind          = kind;
    row.op.exit_number   = exitnum;
    row.reps             = reps[4:0];
    row.typed            = typed;
    row.want.exit_result = w_exit;
    row.want.not_empty   = w_ne;
    row.want.status      = w_st;
    row.want.level       = w_lvl;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Entered at a falling edge; returns at the rising edge that takes the transfer.
  task automatic offer(input in_item_t it);
    int unsigned                 gap;
    logic [$bits(in_item_t)-1:0] noise;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        noise = $urandom;
        in_valid_i <= 1'b0;
        in_item_i  <= noise;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
    end
    burst_left--;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_accepted++;
  endtask

  initial begin : sender
    in_item_t    it;
    out_item_t   predicted;
    int unsigned n_counted;
    n_counted = 0;

    add_row(ACT_POP,        KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 5'd0);
    add_row(ACT_BREAK,      KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 5'd0);
    add_row(ACT_BREAK_USED, KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 5'd0);
    add_row(ACT_TOP,        KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_OK,    5'd0);
    add_row(ACT_CONT,       KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_OK,    5'd0);
    add_row(ACT_CONT_USED,  KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_OK,    5'd0);
    add_row(ACT_PUSH,       KIND_SWITCH, 16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_ZERO,  5'd0);
    add_row(ACT_PUSH,       KIND_LOOP,   16'hFFFF,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd1);
    add_row(ACT_PUSH,       KIND_SWITCH, 16'h0001,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd2);
    add_row(ACT_BREAK_USED, KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd2);
    add_row(ACT_BREAK,      KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0001, 1'b1, ST_OK,    5'd2);
    add_row(ACT_BREAK_USED, KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0001, 1'b1, ST_OK,    5'd2);
    add_row(ACT_CONT_USED,  KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd2);
    add_row(ACT_CONT,       KIND_LOOP,   16'h0000,  1, 1'b1, 16'hFFFF, 1'b1, ST_OK,    5'd2);
    add_row(ACT_CONT_USED,  KIND_LOOP,   16'h0000,  1, 1'b1, 16'hFFFF, 1'b1, ST_OK,    5'd2);
    add_row(ACT_TOP,        KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0001, 1'b1, ST_OK,    5'd2);
    add_row(ACT_NONE,       KIND_SWITCH, 16'hFFFF,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd2);
    add_row(ACT_POP,        KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd1);
    add_row(ACT_BREAK,      KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b1, ST_OK,    5'd1);
    add_row(ACT_PUSH,       KIND_SWITCH, 16'h5AA5, 15, 1'b0, 16'h0000, 1'b0, ST_OK,    5'd0);
    add_row(ACT_PUSH,       KIND_LOOP,   16'h1234,  1, 1'b1, 16'h0000, 1'b1, ST_FULL,  5'd16);
    add_row(ACT_PUSH,       KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b1, ST_ZERO,  5'd16);
    add_row(ACT_CONT,       KIND_LOOP,   16'h0000,  1, 1'b1, 16'hFFFF, 1'b1, ST_OK,    5'd16);
    add_row(ACT_TOP,        KIND_LOOP,   16'h0000,  1, 1'b1, 16'h5AA5, 1'b1, ST_OK,    5'd16);
    add_row(ACT_POP,        KIND_LOOP,   16'h0000, 16, 1'b0, 16'h0000, 1'b0, ST_OK,    5'd0);
    add_row(ACT_POP,        KIND_LOOP,   16'h0000,  1, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 5'd0);

    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        offer(dir_rows[r].op);
        predicted = step_stack(dir_rows[r].op);
        pending_results.insert(pending_results.size(),
                               dir_rows[r].typed ? dir_rows[r].want : predicted);
        @(negedge clk_i);
      end
    end
    n_directed = n_accepted;

    while (n_counted < N_RANDOM) begin
      it = draw_op((n_counted / 40) % 3);
      offer(it);
      predicted = step_stack(it);
      pending_results.insert(pending_results.size(), predicted);
      if (it.action != ACT_NONE) n_counted++;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run: %0d transfers in (%0d directed), %0d results checked",
             n_accepted, n_directed, n_checked);
    $display("stack: deepest %0d, %0d full, %0d zero-exit, %0d empty errors, walk up to %0d",
             deepest, n_full, n_zero, n_empty, longest_walk);
    if (n_mismatch == 0) begin
      $display("loop_switch_exit_stack_core: match");
    end else begin
      $display("loop_switch_exit_stack_core: mismatch");
    end
    $finish;
  end

  // Output stall pattern, with one long hold-off that backs the block up.
  initial begin : receiver
    int unsigned tick;
    int unsigned mode;
    logic        held_off;
    tick     = 0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && n_accepted >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      mode = (tick / 50) % 4;
      tick++;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= $urandom_range(0, 1);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (tick % 5 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: exit=%h ne=%b st=%0d lvl=%0d", $realtime,
                   out_item_o.exit_result, out_item_o.not_empty, out_item_o.status,
                   out_item_o.level);
        end
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_item_o.exit_result !== want.exit_result ||
            out_item_o.not_empty   !== want.not_empty   ||
            out_item_o.status      !== want.status      ||
            out_item_o.level       !== want.level) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("[%0t] result %0d: want exit=%h ne=%b st=%0d lvl=%0d",
                     $realtime, n_checked, want.exit_result, want.not_empty,
                     want.status, want.level);
            $display("[%0t] result %0d:  got exit=%h ne=%b st=%0d lvl=%0d",
                     $realtime, n_checked, out_item_o.exit_result, out_item_o.not_empty,
                     out_item_o.status, out_item_o.level);
          end
        end
      end
    end
  end

  // Count cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("loop_switch_exit_stack_core: mismatch");
      $finish;
    end
  end

endmodule
